// ===== design/duc_pkg.sv =====
// Shared types, codes and constants of the decimal up/down counter.
package duc_pkg;

  localparam int unsigned DigitW = 4;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned FuncW  = 2;
  localparam int unsigned MatchW = 3;

  typedef logic [DigitW-1:0] digit_t;
  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [FuncW-1:0]  func_t;
  typedef logic [MatchW-1:0] match_t;

  // event kinds
  localparam func_t FuncRx   = 2'd0;
  localparam func_t FuncDown = 2'd1;
  localparam func_t FuncUp   = 2'd2;

  localparam byte_t AsciiZero = 8'd48;
  localparam byte_t AsciiLf   = 8'd10;
  localparam byte_t AsciiCr   = 8'd13;
  localparam byte_t AsciiNul  = 8'd0;
  localparam byte_t AsciiDnLo = 8'h64;  // 'd'
  localparam byte_t AsciiDnUp = 8'h44;  // 'D'
  localparam byte_t AsciiUpLo = 8'h75;  // 'u'
  localparam byte_t AsciiUpUp = 8'h55;  // 'U'

  localparam digit_t DigitMax = 4'd9;

  // index of the final character of "Reset"
  localparam match_t MatchLast = 3'd4;

  // control word shared by every digit cell
  typedef struct packed {
    logic up;     // count direction for this event
    logic clr;    // clear the count
    logic load;   // copy new count into the report shifter
    logic shift;  // advance the report shifter by one digit
  } cell_ctrl_t;

  function automatic byte_t match_char(match_t pos);
    byte_t c;
    case (pos)
      3'd0:    c = 8'h52;  // R
      3'd1:    c = 8'h65;  // e
      3'd2:    c = 8'h73;  // s
      3'd3:    c = 8'h65;  // e
      3'd4:    c = 8'h74;  // t
      default: c = AsciiNul;
    endcase
    return c;
  endfunction

endpackage

// ===== design/duc_in_if.sv =====
// Event channel: event kind and received byte.
interface duc_in_if;
  import duc_pkg::*;

  logic  valid;
  logic  ready;
  func_t func;
  byte_t rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

// ===== design/duc_out_if.sv =====
// Report channel: one transmit byte per word, last flags the closing byte.
interface duc_out_if;
  import duc_pkg::*;

  logic  valid;
  logic  ready;
  byte_t tx_byte;
  logic  last;

  modport source (output valid, output tx_byte, output last, input ready);
  modport sink   (input valid, input tx_byte, input last, output ready);
endinterface

// ===== design/duc_digit_cell.sv =====
// One BCD digit of the count plus its stage of the report shifter.
module duc_digit_cell
  import duc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       en_i,        // carry/borrow from the less significant cell
  output logic       carry_o,     // carry/borrow to the more significant cell
  input  digit_t     shift_in_i,  // report digit from the less significant cell
  output digit_t     shift_o
);

  digit_t digit_d, digit_q;
  digit_t sh_d, sh_q;
  logic   wrap;

  always_comb begin
    if (ctrl_i.up) begin
      wrap = (digit_q >= DigitMax);
    end else begin
      wrap = (digit_q == '0) || (digit_q > DigitMax);
    end
    carry_o = en_i && wrap;
  end

  always_comb begin
    if (ctrl_i.clr) begin
      digit_d = '0;
    end else if (en_i) begin
      if (ctrl_i.up) begin
        digit_d = wrap ? digit_t'(0) : digit_q + digit_t'(1);
      end else begin
        digit_d = wrap ? DigitMax : digit_q - digit_t'(1);
      end
    end else begin
      digit_d = digit_q;
    end
  end

  always_comb begin
    if (ctrl_i.load) begin
      sh_d = digit_d;
    end else if (ctrl_i.shift) begin
      sh_d = shift_in_i;
    end else begin
      sh_d = sh_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign shift_o = sh_q;

endmodule

// ===== design/decimal_updown_counter_uart_report.sv =====
// Top level: decimal up/down counter with byte-wise serial report.
//
// in_i carries events: func 0 is a received byte, 1 the down button, 2 the
// up button, 3 is ignored. Bytes 'd'/'D' count down, 'u'/'U' count up, and
// the bytes of "Reset" in order clear the count on the final 't'.
// Each change sends a report on out_o: NUM_DIGITS ASCII digits, most
// significant first, then LF, CR and a zero byte flagged by last.
// The count sits in a row of digit cells; carries ripple from the least
// significant cell, and each cell also holds one stage of the report
// shifter, which moves the digits toward the head cell one word at a time.
// Latency: the first report word is valid the cycle after the event word
// is accepted. A report occupies NUM_DIGITS + 3 output words; in_i.ready is
// high while no report is pending and again in the cycle the closing word
// is taken, so a new event waits for the closing word of the last report,
// and silent events are taken one per cycle while idle.
// Reset clears the count to zero, the match position and any pending report.
// When the receiver stalls, the current word holds and in_i.ready stays low.
module decimal_updown_counter_uart_report
  import duc_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  duc_in_if.sink    in_i,
  duc_out_if.source out_o
);

  localparam int unsigned RepLen = NUM_DIGITS + 3;
  localparam int unsigned CntW   = $clog2(RepLen);
  localparam logic [CntW-1:0] IdxLf   = CntW'(NUM_DIGITS);
  localparam logic [CntW-1:0] IdxCr   = CntW'(NUM_DIGITS + 1);
  localparam logic [CntW-1:0] IdxLast = CntW'(NUM_DIGITS + 2);

  logic           acc_in, out_take, last_beat;
  logic           cnt_ev, emit;
  cell_ctrl_t     ctrl;
  match_t         match_d, match_q;
  logic           busy_d, busy_q;
  logic [CntW-1:0] cnt_d, cnt_q;

  logic   [NUM_DIGITS:0]   carry;
  digit_t [NUM_DIGITS:0]   shift;

  assign acc_in    = in_i.valid && in_i.ready;
  assign out_take  = out_o.valid && out_o.ready;
  assign last_beat = (cnt_q == IdxLast);

  assign in_i.ready = !busy_q || (out_o.ready && last_beat);

  // event decode, "Reset" matcher and cell control
  always_comb begin
    cnt_ev     = 1'b0;
    emit       = 1'b0;
    ctrl.up    = 1'b0;
    ctrl.clr   = 1'b0;
    ctrl.shift = out_take && (cnt_q < IdxLf);
    match_d    = match_q;
    if (acc_in) begin
      case (in_i.func)
        FuncDown: begin
          cnt_ev = 1'b1;
          emit   = 1'b1;
        end
        FuncUp: begin
          cnt_ev  = 1'b1;
          ctrl.up = 1'b1;
          emit    = 1'b1;
        end
        FuncRx: begin
          if (in_i.rx_byte == match_char(match_q)) begin
            if (match_q == MatchLast) begin
              match_d  = '0;
              ctrl.clr = 1'b1;
              emit     = 1'b1;
            end else begin
              match_d = match_q + match_t'(1);
            end
          end else begin
            match_d = '0;
          end
          // no character of "Reset" is a count command
          if (in_i.rx_byte inside {AsciiDnLo, AsciiDnUp}) begin
            cnt_ev = 1'b1;
            emit   = 1'b1;
          end else if (in_i.rx_byte inside {AsciiUpLo, AsciiUpUp}) begin
            cnt_ev  = 1'b1;
            ctrl.up = 1'b1;
            emit    = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    ctrl.load = emit;
  end

  // report sequencer
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (emit) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (out_take) begin
      if (last_beat) begin
        busy_d = 1'b0;
        cnt_d  = '0;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
      busy_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      match_q <= match_d;
      busy_q  <= busy_d;
      cnt_q   <= cnt_d;
    end
  end

  // cell i is digit i, index 0 most significant; carries run downward
  assign carry[NUM_DIGITS] = cnt_ev;
  assign shift[NUM_DIGITS] = '0;

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    duc_digit_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .en_i       (carry[i+1]),
      .carry_o    (carry[i]),
      .shift_in_i (shift[i+1]),
      .shift_o    (shift[i])
    );
  end

  always_comb begin
    if (cnt_q < IdxLf) begin
      out_o.tx_byte = {{(ByteW-DigitW){1'b0}}, shift[0]} + AsciiZero;
    end else if (cnt_q == IdxLf) begin
      out_o.tx_byte = AsciiLf;
    end else if (cnt_q == IdxCr) begin
      out_o.tx_byte = AsciiCr;
    end else begin
      out_o.tx_byte = AsciiNul;
    end
  end

  assign out_o.valid = busy_q;
  assign out_o.last  = last_beat;

endmodule

// ===== design/duc_checker.sv =====
// Port-level checks for the counter top level, bound to every instance.
module duc_checker
  import duc_pkg::*;
(
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_i,
  input func_t in_func_i,
  input logic  out_valid_i,
  input logic  out_ready_i,
  input byte_t out_tx_byte_i,
  input logic  out_last_i
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_tx_byte_i)
      && $stable(out_last_i))
    else $error("report word changed while stalled");

  // a button event starts a report with a digit word
  a_btn_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_func_i == FuncDown || in_func_i == FuncUp)
      |=> out_valid_i && !out_last_i && out_tx_byte_i >= AsciiZero
        && out_tx_byte_i <= (AsciiZero + 8'd9))
    else $error("button event did not start a report");

  // no new event mid-report
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("event accepted in the middle of a report");

  // closing word taken with no new event leaves the channel idle
  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_last_i && !in_valid_i |=> !out_valid_i)
    else $error("report continued past its closing word");

endmodule

bind decimal_updown_counter_uart_report duc_checker u_duc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_func_i     (in_i.func),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_tx_byte_i (out_o.tx_byte),
  .out_last_i    (out_o.last)
);

// ===== sim/testbench.sv =====
// Self-checking bench for the decimal up/down counter and its serial report.
`timescale 1ns / 1ps

module testbench;
  import duc_pkg::*;

  localparam int unsigned NumDigits = 4;
  localparam int unsigned ResetLen  = 5;
  localparam int unsigned CycleCap  = 400000;
  localparam int unsigned TailWait  = 20;
  localparam int unsigned RandWords = 210;
  localparam func_t       FuncNone  = 2'd3;

  typedef struct {
    func_t       func;
    byte_t       rx;
    int unsigned gap;
    bit          drain;
  } event_word_t;

  typedef struct packed {
    byte_t tx;
    logic  last;
  } report_word_t;

  logic clk_i;
  logic rst_ni;

  duc_in_if  ev_if ();
  duc_out_if rpt_if ();

  decimal_updown_counter_uart_report #(
    .NUM_DIGITS(NumDigits)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (ev_if),
    .out_o (rpt_if)
  );

  // predicted count, match progress and expected report bytes
  digit_t       count_digits[NumDigits] = '{default: '0};
  int unsigned  match_idx = 0;
  byte_t        reset_text[ResetLen] = '{8'h52, 8'h65, 8'h73, 8'h65, 8'h74};
  report_word_t report_bytes_q[$];

  event_word_t  event_words_q[$];
  bit           sender_idle;
  bit           receiver_idle;
  bit           drain_next;
  int unsigned  active_words;

  bit           in_taken;
  bit           rpt_taken;
  bit           gap_armed;
  int unsigned  gap_left;
  int unsigned  stall_left;
  int unsigned  err_count;
  int unsigned  cycles;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic bump_count(input bit up);
    bit done;
    done = 1'b0;
    for (int i = NumDigits - 1; i >= 0 && !done; i--) begin
      if (up) begin
        if (count_digits[i] >= DigitMax) begin
          count_digits[i] = '0;
        end else begin
          count_digits[i] = count_digits[i] + 1'b1;
          done = 1'b1;
        end
      end else begin
        if (count_digits[i] == 0 || count_digits[i] > DigitMax) begin
          count_digits[i] = DigitMax;
        end else begin
          count_digits[i] = count_digits[i] - 1'b1;
          done = 1'b1;
        end
      end
    end
  endtask

  task automatic push_report();
    for (int i = 0; i < NumDigits; i++)
      report_bytes_q.push_back('{AsciiZero + byte_t'(count_digits[i]), 1'b0});
    report_bytes_q.push_back('{AsciiLf, 1'b0});
    report_bytes_q.push_back('{AsciiCr, 1'b0});
    report_bytes_q.push_back('{AsciiNul, 1'b1});
  endtask

  // advance the predicted state by one accepted event word
  task automatic count_event(input func_t f, input byte_t b);
    bit cleared;
    cleared = 1'b0;
    case (f)
      FuncDown: begin
        bump_count(1'b0);
        push_report();
      end
      FuncUp: begin
        bump_count(1'b1);
        push_report();
      end
      FuncRx: begin
        if (match_idx < ResetLen && b == reset_text[match_idx]) begin
          match_idx++;
          if (match_idx == ResetLen) begin
            match_idx = 0;
            count_digits = '{default: '0};
            push_report();
            cleared = 1'b1;
          end
        end else begin
          match_idx = 0;  // no retry of this byte as a first character
        end
        if (!cleared) begin
          if (b == AsciiDnLo || b == AsciiDnUp) begin
            bump_count(1'b0);
            push_report();
          end else if (b == AsciiUpLo || b == AsciiUpUp) begin
            bump_count(1'b1);
            push_report();
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic void queue_event(input func_t f, input byte_t b);
    event_word_t w;
    w.func  = f;
    w.rx    = b;
    w.gap   = sender_idle ? $urandom_range(0, 14) : 0;
    w.drain = drain_next;
    drain_next = 1'b0;
    event_words_q.push_back(w);
    active_words++;
  endfunction

  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++)
      queue_event(FuncRx, byte_t'(s[i]));
  endfunction

  function automatic void queue_random_burst();
    int unsigned r;
    int unsigned n;
    byte_t       cmds[4];
    cmds = '{AsciiDnLo, AsciiDnUp, AsciiUpLo, AsciiUpUp};
    r = $urandom_range(0, 99);
    if (r < 30) begin
      queue_event($urandom_range(0, 1) ? FuncUp : FuncDown, byte_t'($urandom_range(0, 255)));
    end else if (r < 55) begin
      queue_event(FuncRx, cmds[$urandom_range(0, 3)]);
    end else if (r < 75) begin
      for (int i = 0; i < ResetLen; i++) begin
        // a button in the middle of a match keeps the match alive
        if ($urandom_range(0, 9) == 0)
          queue_event($urandom_range(0, 1) ? FuncUp : FuncDown, byte_t'($urandom));
        queue_event(FuncRx, reset_text[i]);
      end
    end else if (r < 85) begin
      n = $urandom_range(1, ResetLen - 1);
      for (int i = 0; i < n; i++)
        queue_event(FuncRx, reset_text[i]);
      queue_event(FuncRx, $urandom_range(0, 1) ? cmds[$urandom_range(0, 3)]
                                               : byte_t'($urandom_range(0, 255)));
    end else if (r < 93) begin
      queue_event(FuncNone, byte_t'($urandom_range(0, 255)));
    end else begin
      queue_event(FuncRx, byte_t'($urandom_range(0, 255)));
    end
  endfunction

  // sender: new word at the falling edge once the previous one was taken
  always @(negedge clk_i) begin
    bit          nxt_valid;
    event_word_t w;
    if (!rst_ni) begin
      ev_if.valid <= 1'b0;
    end else if (!(ev_if.valid && !in_taken)) begin
      nxt_valid = 1'b0;
      if (!gap_armed && event_words_q.size() > 0) begin
        gap_left  = event_words_q[0].gap;
        gap_armed = 1'b1;
      end
      if (gap_armed && gap_left == 0 &&
          !(event_words_q[0].drain && report_bytes_q.size() > 0)) begin
        w = event_words_q.pop_front();
        gap_armed = 1'b0;
        nxt_valid = 1'b1;
        ev_if.func    <= w.func;
        ev_if.rx_byte <= w.rx;
      end else if (gap_armed && gap_left > 0) begin
        gap_left--;
      end
      ev_if.valid <= nxt_valid;
    end
  end

  // receiver stall per report byte
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rpt_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      rpt_if.ready <= 1'b0;
      stall_left--;
    end else begin
      rpt_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    report_word_t exp_w;
    if (rst_ni) begin
      in_taken = ev_if.valid && ev_if.ready;
      if (in_taken)
        count_event(ev_if.func, ev_if.rx_byte);
      rpt_taken = rpt_if.valid && rpt_if.ready;
      if (rpt_taken) begin
        if (report_bytes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word tx=%0d last=%0b",
                                    rpt_if.tx_byte, rpt_if.last));
        end else begin
          exp_w = report_bytes_q.pop_front();
          if (rpt_if.tx_byte !== exp_w.tx)
            report_mismatch($sformatf("tx_byte %0d, want %0d", rpt_if.tx_byte, exp_w.tx));
          if (rpt_if.last !== exp_w.last)
            report_mismatch($sformatf("last %0b, want %0b", rpt_if.last, exp_w.last));
        end
        stall_left = receiver_idle ? $urandom_range(0, 14) : 0;
      end
    end else begin
      in_taken  = 1'b0;
      rpt_taken = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleCap) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    ev_if.valid   = 1'b0;
    ev_if.func    = FuncRx;
    ev_if.rx_byte = '0;
    rpt_if.ready  = 1'b0;
    rst_ni        = 1'b0;
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    drain_next    = 1'b0;
    active_words  = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: wrap both ways, command bytes, match corner cases
    queue_event(FuncDown, 8'h00);
    queue_event(FuncUp, 8'hff);
    queue_text("uUdD");
    queue_text("RReset");   // second R breaks the match and is not retried
    queue_text("Re");
    queue_event(FuncUp, 8'h00);
    drain_next = 1'b1;
    queue_text("set");      // button kept the match, so this clears
    queue_event(FuncRx, 8'hff);
    queue_event(FuncRx, 8'h00);
    queue_event(FuncNone, AsciiUpLo);
    queue_text("Rd");       // mismatch still counts down
    while (event_words_q.size() != 0 || ev_if.valid) @(posedge clk_i);

    // random phases share the word budget with the directed part
    for (int ph = 0; ph < 6; ph++) begin
      sender_idle   = ph[0];
      receiver_idle = ph[1] | (ph == 5);
      drain_next    = (ph == 3);
      while (active_words < RandWords * (ph + 1) / 6)
        queue_random_burst();
      while (event_words_q.size() != 0 || ev_if.valid) @(posedge clk_i);
    end

    while (report_bytes_q.size() != 0) @(posedge clk_i);
    repeat (TailWait) @(posedge clk_i);
    if (err_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
